// File: design/tsfd_pkg.sv
// Shared constants, widths and codes for the stereo feedback delay.
// No dependencies; imported by the delay core and its port checker.
`timescale 1ns / 1ps

package tsfd_pkg;

  // Store geometry and sample width
  localparam int DELAY_DEPTH = 131072;
  localparam int SAMPLE_BITS = 24;

  localparam int ADDR_W = $clog2(DELAY_DEPTH);
  localparam int LEN_W  = ADDR_W + 1;   // holds DELAY_DEPTH itself
  localparam int WORD_W = 2 * SAMPLE_BITS;

  // Field and register widths
  localparam int TEMPO_W   = 14;
  localparam int QB_W      = 5;
  localparam int RATE_W    = 18;
  localparam int GAIN_W    = 16;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;

  // Length arithmetic: rate*240 < rate*256, times the quarter count
  localparam int MCAND_W = RATE_W + 8;
  localparam int PROD_W  = MCAND_W + QB_W;
  localparam int DIV_W   = (LEN_W > TEMPO_W) ? LEN_W : TEMPO_W;
  localparam int CNT_W   = $clog2(PROD_W);

  // Gain accumulators: sample plus headroom for two Q1.15 terms
  localparam int ACC_W = SAMPLE_BITS + 4;

  // Register reset values
  localparam logic [QB_W-1:0]   QB_RST   = QB_W'(3);
  localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(48000);
  localparam logic [GAIN_W-1:0] FB_RST   = GAIN_W'(24576);
  localparam logic [GAIN_W-1:0] DRY_RST  = GAIN_W'(24576);
  localparam logic [GAIN_W-1:0] WET_RST  = GAIN_W'(13107);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUARTERS = 3'd0,
    REG_RATE     = 3'd1,
    REG_FEEDBACK = 3'd2,
    REG_DRY      = 3'd3,
    REG_WET      = 3'd4
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_WB,
    ST_LMUL,
    ST_LDIV,
    ST_CLAMP,
    ST_MOD
  } state_e;

endpackage

// File: design/tempo_synced_stereo_feedback_delay.sv
// Stereo tempo-synced feedback delay: store, serial gain lanes, serial divider.
// Depends on tsfd_pkg.
`timescale 1ns / 1ps
//
//  channel  direction  handshake              payload
//  in       sink       in_valid_i/in_stall_o  action_i tempo_i left_in_i right_in_i
//  out      source     out_valid_o/out_stall_i left_out_o right_out_o
//  cfg      sink       cfg_we_i               cfg_idx_i cfg_data_i
//
//  A sample request takes one store read, one load, GAIN_W shift-add steps over
//  the gain bits and one write-back. A tempo request takes QB_W shift-add steps,
//  PROD_W restoring divide steps for the length, one clamp and ADDR_W divide
//  steps to wrap the position; both divides share the one-bit divider. No
//  clearing pass after reset: a fill count marks which store entries were
//  written. A result waiting under out_stall_i holds the write-back.

module tempo_synced_stereo_feedback_delay
  import tsfd_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [TEMPO_W-1:0]            tempo_i,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,

  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_W-1:0]              cfg_data_i
);

  // Saturate an accumulator to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
    input logic signed [ACC_W-1:0] v
  );
    logic [ACC_W-SAMPLE_BITS:0] upper;
    upper = v[ACC_W-1:SAMPLE_BITS-1];
    if (upper == '0 || upper == '1) begin
      return v[SAMPLE_BITS-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  endfunction

  // Control state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [ADDR_W-1:0]  pos_q, pos_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [LEN_W-1:0]   fill_q, fill_d;
  logic               out_valid_q, out_valid_d;

  // Configuration
  logic [QB_W-1:0]    qb_q;
  logic [RATE_W-1:0]  rate_q;
  logic [GAIN_W-1:0]  fb_q, dry_q, wet_q;

  // Payload
  logic signed [SAMPLE_BITS-1:0] in_l_q, in_l_d, in_r_q, in_r_d;
  logic signed [SAMPLE_BITS-1:0] dly_l_q, dly_l_d, dly_r_q, dly_r_d;
  logic signed [SAMPLE_BITS-1:0] out_l_q, out_l_d, out_r_q, out_r_d;
  logic signed [ACC_W-1:0]       acc_ol_q, acc_ol_d, acc_or_q, acc_or_d;
  logic signed [ACC_W-1:0]       acc_fl_q, acc_fl_d, acc_fr_q, acc_fr_d;
  logic [GAIN_W-1:0]             fb_sh_q, fb_sh_d, dry_sh_q, dry_sh_d;
  logic [GAIN_W-1:0]             wet_sh_q, wet_sh_d;
  logic [QB_W-1:0]               qb_sh_q, qb_sh_d;
  logic [MCAND_W-1:0]            mcand_q, mcand_d;
  logic [PROD_W-1:0]             div_q, div_d;
  logic [DIV_W-1:0]              rem_q, rem_d, dvs_q, dvs_d;

  // Delay store
  logic [WORD_W-1:0] mem_q [DELAY_DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_we;

  // Datapath helpers
  logic signed [ACC_W-1:0] ext_in_l, ext_in_r, ext_dl, ext_dr;
  logic signed [ACC_W-1:0] sum_ol, sum_or, sum_fl, sum_fr;
  logic signed [ACC_W-1:0] fbk_l, fbk_r;
  logic                    mul_last;
  logic [DIV_W:0]          rem_sh, rem_diff;
  logic                    rem_ge;
  logic [DIV_W-1:0]        rem_nx;
  logic [PROD_W-1:0]       div_nx;
  logic [LEN_W-1:0]        len_new;
  logic [LEN_W-1:0]        pos_inc;
  logic                    hit;
  logic                    out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

  // Gain lanes: one gain bit per cycle, LSB first
  assign ext_in_l = ACC_W'(in_l_q);
  assign ext_in_r = ACC_W'(in_r_q);
  assign ext_dl   = ACC_W'(dly_l_q);
  assign ext_dr   = ACC_W'(dly_r_q);
  assign sum_ol   = acc_ol_q + (dry_sh_q[0] ? ext_in_l : '0) + (wet_sh_q[0] ? ext_dl : '0);
  assign sum_or   = acc_or_q + (dry_sh_q[0] ? ext_in_r : '0) + (wet_sh_q[0] ? ext_dr : '0);
  assign sum_fl   = acc_fl_q + (fb_sh_q[0] ? ext_dl : '0);
  assign sum_fr   = acc_fr_q + (fb_sh_q[0] ? ext_dr : '0);
  assign mul_last = (cnt_q == CNT_W'(GAIN_W - 1));

  // Stored pair: input plus scaled delayed sample
  assign fbk_l     = acc_fl_q + ext_in_l;
  assign fbk_r     = acc_fr_q + ext_in_r;
  assign mem_wdata = {sat_smp(fbk_r), sat_smp(fbk_l)};

  // Restoring divider step, one quotient bit per cycle
  assign rem_sh   = {rem_q, div_q[PROD_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_q};
  assign rem_ge   = ~rem_diff[DIV_W];
  assign rem_nx   = rem_ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
  assign div_nx   = {div_q[PROD_W-2:0], rem_ge};

  // Length clamp to 1..DELAY_DEPTH
  always_comb begin
    if (div_q == '0) begin
      len_new = LEN_W'(1);
    end else if (div_q > PROD_W'(DELAY_DEPTH)) begin
      len_new = LEN_W'(DELAY_DEPTH);
    end else begin
      len_new = div_q[LEN_W-1:0];
    end
  end

  assign pos_inc  = {1'b0, pos_q} + LEN_W'(1);
  assign hit      = ({1'b0, pos_q} < fill_q);
  assign out_free = ~out_valid_q | ~out_stall_i;

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    len_d       = len_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q & out_stall_i;
    in_l_d      = in_l_q;
    in_r_d      = in_r_q;
    dly_l_d     = dly_l_q;
    dly_r_d     = dly_r_q;
    out_l_d     = out_l_q;
    out_r_d     = out_r_q;
    acc_ol_d    = acc_ol_q;
    acc_or_d    = acc_or_q;
    acc_fl_d    = acc_fl_q;
    acc_fr_d    = acc_fr_q;
    fb_sh_d     = fb_sh_q;
    dry_sh_d    = dry_sh_q;
    wet_sh_d    = wet_sh_q;
    qb_sh_d     = qb_sh_q;
    mcand_d     = mcand_q;
    div_d       = div_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    mem_we      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i) begin
            // rate * 240 = rate * 256 - rate * 16
            mcand_d = {rate_q, 8'h00} - {4'h0, rate_q, 4'h0};
            qb_sh_d = qb_q;
            dvs_d   = DIV_W'(tempo_i);
            div_d   = '0;
            cnt_d   = '0;
            state_d = ST_LMUL;
          end else begin
            in_l_d  = left_in_i;
            in_r_d  = right_in_i;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        // Entries past the fill count were never written: read as zero
        dly_l_d  = hit ? rdata_q[SAMPLE_BITS-1:0] : '0;
        dly_r_d  = hit ? rdata_q[WORD_W-1:SAMPLE_BITS] : '0;
        acc_ol_d = '0;
        acc_or_d = '0;
        acc_fl_d = '0;
        acc_fr_d = '0;
        fb_sh_d  = fb_q;
        dry_sh_d = dry_q;
        wet_sh_d = wet_q;
        cnt_d    = '0;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        // Shift after each bit below the top one keeps floor(sum / 2^15)
        acc_ol_d = mul_last ? sum_ol : (sum_ol >>> 1);
        acc_or_d = mul_last ? sum_or : (sum_or >>> 1);
        acc_fl_d = mul_last ? sum_fl : (sum_fl >>> 1);
        acc_fr_d = mul_last ? sum_fr : (sum_fr >>> 1);
        fb_sh_d  = fb_sh_q >> 1;
        dry_sh_d = dry_sh_q >> 1;
        wet_sh_d = wet_sh_q >> 1;
        cnt_d    = cnt_q + CNT_W'(1);
        if (mul_last) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (out_free) begin
          mem_we      = 1'b1;
          out_valid_d = 1'b1;
          out_l_d     = sat_smp(acc_ol_q);
          out_r_d     = sat_smp(acc_or_q);
          if ({1'b0, pos_q} == fill_q) begin
            fill_d = fill_q + LEN_W'(1);
          end
          pos_d   = (pos_inc >= len_q) ? '0 : pos_inc[ADDR_W-1:0];
          state_d = ST_IDLE;
        end
      end
      ST_LMUL: begin
        // Quarter count MSB first
        div_d   = (div_q << 1) + (qb_sh_q[QB_W-1] ? PROD_W'(mcand_q) : '0);
        qb_sh_d = qb_sh_q << 1;
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QB_W - 1)) begin
          rem_d   = '0;
          cnt_d   = '0;
          state_d = ST_LDIV;
        end
      end
      ST_LDIV: begin
        // Zero tempo yields an all-ones quotient, clamped to the depth
        rem_d = rem_nx;
        div_d = div_nx;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(PROD_W - 1)) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        len_d   = len_new;
        div_d   = {pos_q, {(PROD_W - ADDR_W){1'b0}}};
        rem_d   = '0;
        dvs_d   = DIV_W'(len_new);
        cnt_d   = '0;
        state_d = ST_MOD;
      end
      ST_MOD: begin
        // Position modulo the new length
        rem_d = rem_nx;
        div_d = div_nx;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ADDR_W - 1)) begin
          pos_d   = rem_nx[ADDR_W-1:0];
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      len_q       <= LEN_W'(1);
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      len_q       <= len_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qb_q   <= QB_RST;
      rate_q <= RATE_RST;
      fb_q   <= FB_RST;
      dry_q  <= DRY_RST;
      wet_q  <= WET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_QUARTERS: qb_q   <= cfg_data_i[QB_W-1:0];
        REG_RATE:     rate_q <= cfg_data_i[RATE_W-1:0];
        REG_FEEDBACK: fb_q   <= cfg_data_i[GAIN_W-1:0];
        REG_DRY:      dry_q  <= cfg_data_i[GAIN_W-1:0];
        REG_WET:      wet_q  <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    in_l_q   <= in_l_d;
    in_r_q   <= in_r_d;
    dly_l_q  <= dly_l_d;
    dly_r_q  <= dly_r_d;
    out_l_q  <= out_l_d;
    out_r_q  <= out_r_d;
    acc_ol_q <= acc_ol_d;
    acc_or_q <= acc_or_d;
    acc_fl_q <= acc_fl_d;
    acc_fr_q <= acc_fr_d;
    fb_sh_q  <= fb_sh_d;
    dry_sh_q <= dry_sh_d;
    wet_sh_q <= wet_sh_d;
    qb_sh_q  <= qb_sh_d;
    mcand_q  <= mcand_d;
    div_q    <= div_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
  end

  // Delay store: one port at the write position, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[pos_q] <= mem_wdata;
    end
    rdata_q <= mem_q[pos_q];
  end

endmodule

// File: design/tsfd_checker.sv
// Port-level checks for the stereo feedback delay, bound to the top level.
// Depends on tsfd_pkg and tempo_synced_stereo_feedback_delay.
`timescale 1ns / 1ps

module tsfd_checker
  import tsfd_pkg::*;
(
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          action_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic signed [SAMPLE_BITS-1:0] left_out_o,
  input logic signed [SAMPLE_BITS-1:0] right_out_o
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(left_out_o) && $stable(right_out_o))
    else $error("stalled result changed");

  // One request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  // A tempo request produces no result
  a_tempo_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i && !out_valid_o |=> ##1 !out_valid_o)
    else $error("result after tempo request");

  // A new result only comes out of a request in flight
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in flight");

endmodule

bind tempo_synced_stereo_feedback_delay tsfd_checker u_tsfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .action_i    (action_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .left_out_o  (left_out_o),
  .right_out_o (right_out_o)
);

// File: verif/tempo_synced_stereo_feedback_delay_tb.sv
// Self-checking bench for the stereo tempo-synced feedback delay: a directed
// table, then random configuration phases, all results checked in order.
// Depends on tsfd_pkg and tempo_synced_stereo_feedback_delay.
`timescale 1ns / 1ps

module tempo_synced_stereo_feedback_delay_tb;
  import tsfd_pkg::*;

  localparam logic ACT_SAMPLE    = 1'b0;
  localparam logic ACT_TEMPO     = 1'b1;
  localparam int   SETTLE_CYCLES = 80;       // longer than a tempo request
  localparam int   CYCLE_LIMIT   = 1000000;
  localparam int   RAND_PHASES   = 8;
  localparam int   PHASE_ITEMS   = 125;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  localparam sample_t SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    sample_t left;
    sample_t right;
  } pair_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_TEMPO, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    cfg_reg_e           reg_idx;
    logic [CFG_W-1:0]   reg_data;
    logic [TEMPO_W-1:0] tempo;
    sample_t            left;
    sample_t            right;
    logic               fixed;
    sample_t            exp_left;
    sample_t            exp_right;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  action_i;
  logic [TEMPO_W-1:0]    tempo_i;
  sample_t               left_in_i;
  sample_t               right_in_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  sample_t               left_out_o;
  sample_t               right_out_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;

  // Model copy of the registers and the delay store
  logic [QB_W-1:0]   m_quarters;
  logic [RATE_W-1:0] m_rate;
  logic [GAIN_W-1:0] m_fb;
  logic [GAIN_W-1:0] m_dry;
  logic [GAIN_W-1:0] m_wet;
  sample_t           echo_left  [DELAY_DEPTH];
  sample_t           echo_right [DELAY_DEPTH];
  int                echo_pos;
  int                echo_len;

  pair_t     mixed_pair_q [$];
  pair_t     want_mix;
  stim_row_t dir_rows [$];
  int        fail_cnt = 0;
  int        cycle_cnt;
  int        stall_left = 0;
  int        stall_roll;
  bit        stall_hold = 1'b0;
  bit        quiet_run;

  tempo_synced_stereo_feedback_delay i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .tempo_i     (tempo_i),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic sample_t clip(longint v);
    if (v > longint'(SMP_MAX)) return SMP_MAX;
    if (v < longint'(SMP_MIN)) return SMP_MIN;
    return sample_t'(v);
  endfunction

  // Advance the delay line by one request; returns 1 when a mixed pair comes out
  function automatic bit delay_line_step(logic act, logic [TEMPO_W-1:0] tempo,
                                         sample_t l, sample_t r, output pair_t mix);
    longint span;
    longint dl;
    longint dr;
    longint fb;
    longint dry;
    longint wet;
    mix = '0;
    if (act == ACT_TEMPO) begin
      // quarters * rate * 240 / tempo, clamped into 1..depth
      if (tempo == '0) begin
        span = DELAY_DEPTH;
      end else begin
        span = (longint'(m_quarters) * longint'(m_rate) * 240) / longint'(tempo);
        if (span < 1) span = 1;
        if (span > DELAY_DEPTH) span = DELAY_DEPTH;
      end
      echo_len = int'(span);
      echo_pos = echo_pos % echo_len;
      return 1'b0;
    end
    fb  = m_fb;
    dry = m_dry;
    wet = m_wet;
    dl  = echo_left[echo_pos];
    dr  = echo_right[echo_pos];
    // Q1.15 products floor toward minus infinity via arithmetic shift
    echo_left[echo_pos]  = clip(longint'(l) + ((dl * fb) >>> 15));
    echo_right[echo_pos] = clip(longint'(r) + ((dr * fb) >>> 15));
    echo_pos++;
    if (echo_pos >= echo_len) echo_pos = 0;
    mix.left  = clip((longint'(l) * dry + dl * wet) >>> 15);
    mix.right = clip((longint'(r) * dry + dr * wet) >>> 15);
    return 1'b1;
  endfunction

  function automatic stim_row_t row_sample(sample_t l, sample_t r, logic fx = 1'b0,
                                           sample_t el = '0, sample_t er = '0);
    stim_row_t row;
    row           = '0;
    row.kind      = ROW_SAMPLE;
    row.tempo     = TEMPO_W'($urandom);
    row.left      = l;
    row.right     = r;
    row.fixed     = fx;
    row.exp_left  = el;
    row.exp_right = er;
    return row;
  endfunction

  function automatic stim_row_t row_tempo(logic [TEMPO_W-1:0] t);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_TEMPO;
    row.tempo = t;
    return row;
  endfunction

  function automatic stim_row_t row_reg(cfg_reg_e idx, logic [CFG_W-1:0] d);
    stim_row_t row;
    row          = '0;
    row.kind     = ROW_REG;
    row.reg_idx  = idx;
    row.reg_data = d;
    return row;
  endfunction

  function automatic sample_t rand_sample();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return ($urandom_range(0, 1) != 0) ? SMP_MAX : SMP_MIN;
    if (roll < 3) return sample_t'(int'($urandom_range(0, 511)) - 256);
    return sample_t'($urandom);
  endfunction

  function automatic logic [CFG_W-1:0] rand_gain();
    if ($urandom_range(0, 5) == 0) return CFG_W'($urandom_range(32769, 65535));
    return CFG_W'($urandom_range(0, 32768));
  endfunction

  // One request on the input channel, with a random gap ahead of it
  task automatic send_request(logic act, logic [TEMPO_W-1:0] tempo, sample_t l,
                              sample_t r, bit fixed, pair_t fixed_mix);
    int    gap;
    int    roll;
    pair_t mix;
    roll = $urandom_range(0, 99);
    if (quiet_run || roll < 55) gap = 0;
    else if (roll < 88) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 80);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    tempo_i    <= tempo;
    left_in_i  <= l;
    right_in_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    if (delay_line_step(act, tempo, l, r, mix)) begin
      mixed_pair_q.push_back(fixed ? fixed_mix : mix);
    end
  endtask

  // Wait for every pending result, then long enough for a tempo request to end
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (mixed_pair_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_QUARTERS: m_quarters = data[QB_W-1:0];
      REG_RATE:     m_rate     = data[RATE_W-1:0];
      REG_FEEDBACK: m_fb       = data[GAIN_W-1:0];
      REG_DRY:      m_dry      = data[GAIN_W-1:0];
      REG_WET:      m_wet      = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Output side: random stall runs, mostly short, now and then long
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      stall_hold = (stall_roll < 30);
      stall_left = (stall_roll < 2) ? $urandom_range(15, 70) : $urandom_range(0, 4);
    end
    out_stall_i <= stall_hold && !quiet_run;
  end

  // Result checker: each accepted pair against the oldest pending one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mixed_pair_q.size() == 0) begin
        $display("%0t: result with none pending: left %0d right %0d",
                 $time, left_out_o, right_out_o);
        fail_cnt++;
      end else begin
        want_mix = mixed_pair_q.pop_front();
        if (left_out_o !== want_mix.left) begin
          $display("%0t: left_out expected %0d got %0d", $time, want_mix.left, left_out_o);
          fail_cnt++;
        end
        if (right_out_o !== want_mix.right) begin
          $display("%0t: right_out expected %0d got %0d", $time, want_mix.right, right_out_o);
          fail_cnt++;
        end
      end
    end
  end

  // Run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tempo_synced_stereo_feedback_delay_tb: done, errors");
    $finish;
  end

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    action_i    <= ACT_SAMPLE;
    tempo_i     <= '0;
    left_in_i   <= '0;
    right_in_i  <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_QUARTERS;
    cfg_data_i  <= '0;
    quiet_run   <= 1'b0;
    m_quarters  = QB_RST;
    m_rate      = RATE_RST;
    m_fb        = FB_RST;
    m_dry       = DRY_RST;
    m_wet       = WET_RST;
    echo_pos    = 0;
    echo_len    = 1;
    for (int i = 0; i < DELAY_DEPTH; i++) begin
      echo_left[i]  = '0;
      echo_right[i] = '0;
    end

    // Directed part: extremes, all request kinds, the length corner cases
    dir_rows = '{
      row_sample(SMP_MAX, SMP_MIN, 1'b1, 24'sd6291455, -24'sd6291456),
      row_sample('0, '0),
      row_sample(SMP_MIN, SMP_MAX),
      row_sample(-24'sd1, 24'sd1),
      row_tempo('0),                       // tempo zero: full depth
      row_sample(24'sd12345, -24'sd54321),
      row_sample(SMP_MAX, SMP_MAX),
      row_tempo(14'd1),                    // length far past depth
      row_tempo(14'h3FFF),
      row_sample(24'sh555555, 24'shAAAAAA),
      row_reg(REG_QUARTERS, 18'd0),
      row_tempo(14'd480),                  // zero beats: length one
      row_sample(24'sd7, -24'sd7),
      row_reg(REG_QUARTERS, 18'd16),
      row_sample(24'sd100, 24'sd200),      // no length change before a tempo request
      row_reg(REG_RATE, 18'd0),
      row_tempo(14'd16000),                // zero rate: length one
      row_reg(REG_FEEDBACK, 18'd65535),
      row_reg(REG_DRY, 18'd65535),
      row_reg(REG_WET, 18'd65535),         // gains above one, outputs saturate
      row_sample(SMP_MAX, SMP_MIN),
      row_sample(SMP_MIN, SMP_MAX),
      row_reg(REG_RATE, 18'd100),
      row_reg(REG_QUARTERS, 18'd31),
      row_tempo(14'd5000),
      row_sample(24'sd1000, -24'sd1000),
      row_sample(SMP_MAX, SMP_MAX)
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_REG: begin
          drain_and_settle();
          write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
        end
        ROW_TEMPO: send_request(ACT_TEMPO, dir_rows[i].tempo, rand_sample(), rand_sample(),
                                1'b0, '0);
        default: send_request(ACT_SAMPLE, dir_rows[i].tempo, dir_rows[i].left,
                              dir_rows[i].right, dir_rows[i].fixed,
                              '{dir_rows[i].exp_left, dir_rows[i].exp_right});
      endcase
    end

    // Random phases: each one a new register setting, then a stream of requests
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_and_settle();
      case (ph)
        0: begin
          write_reg(REG_QUARTERS, 18'd1);
          write_reg(REG_RATE, 18'd8000);
          write_reg(REG_FEEDBACK, 18'd0);
          write_reg(REG_DRY, 18'd32768);
          write_reg(REG_WET, 18'd0);
        end
        1: begin
          write_reg(REG_QUARTERS, 18'd16);
          write_reg(REG_RATE, 18'd192000);
          write_reg(REG_FEEDBACK, 18'd32768);
          write_reg(REG_DRY, 18'd0);
          write_reg(REG_WET, 18'd32768);
        end
        2: begin
          // all data bits set; upper bits drop off the narrow registers
          write_reg(REG_QUARTERS, '1);
          write_reg(REG_RATE, '1);
          write_reg(REG_FEEDBACK, '1);
          write_reg(REG_DRY, '1);
          write_reg(REG_WET, '1);
        end
        default: begin
          // short delays so that feedback wraps many times
          write_reg(REG_QUARTERS, ($urandom_range(0, 7) == 0) ? 18'd0 :
                                  CFG_W'($urandom_range(1, 16)));
          write_reg(REG_RATE, CFG_W'($urandom_range(1, 400)));
          write_reg(REG_FEEDBACK, rand_gain());
          write_reg(REG_DRY, rand_gain());
          write_reg(REG_WET, rand_gain());
        end
      endcase
      quiet_run <= (ph == 4);
      send_request(ACT_TEMPO, TEMPO_W'($urandom_range(480, 16000)), rand_sample(),
                   rand_sample(), 1'b0, '0);
      for (int k = 1; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          case ($urandom_range(0, 19))
            0:       send_request(ACT_TEMPO, '0, rand_sample(), rand_sample(), 1'b0, '0);
            1, 2, 3: send_request(ACT_TEMPO, TEMPO_W'($urandom), rand_sample(),
                                  rand_sample(), 1'b0, '0);
            default: send_request(ACT_TEMPO, TEMPO_W'($urandom_range(480, 16000)),
                                  rand_sample(), rand_sample(), 1'b0, '0);
          endcase
        end else begin
          send_request(ACT_SAMPLE, TEMPO_W'($urandom), rand_sample(), rand_sample(),
                       1'b0, '0);
        end
      end
    end

    quiet_run <= 1'b0;
    drain_and_settle();
    if (fail_cnt == 0 && mixed_pair_q.size() == 0) begin
      $display("tempo_synced_stereo_feedback_delay_tb: done, clean");
    end else begin
      $display("tempo_synced_stereo_feedback_delay_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
design/tsfd_pkg.sv
design/tempo_synced_stereo_feedback_delay.sv
design/tsfd_checker.sv
verif/tempo_synced_stereo_feedback_delay_tb.sv
